// File: rtl/core/smpa_pkg.sv
// Shared types, widths and register codes for the strided max pooling block.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package smpa_pkg;

    localparam int VAL_W      = 16;   // signed Q8.8 sample
    localparam int IDX_W      = 20;   // flat source index
    localparam int WIN_REG_W  = 4;    // window and step registers
    localparam int DIM_W      = 11;   // plane width and height registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_DATA_W = 40;
    localparam int PAD_W      = OUT_DATA_W - VAL_W - IDX_W;
    localparam int NUM_REGS   = 6;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIN_W   = 3'd0,
        REG_WIN_H   = 3'd1,
        REG_STEP_X  = 3'd2,
        REG_STEP_Y  = 3'd3,
        REG_PLANE_W = 3'd4,
        REG_PLANE_H = 3'd5
    } cfg_reg_t;

    localparam logic [WIN_REG_W-1:0] WIN_RESET   = 4'd2;
    localparam logic [WIN_REG_W-1:0] STEP_RESET  = 4'd2;
    localparam logic [DIM_W-1:0]     PLANE_RESET = 11'd1024;
    localparam int unsigned          STEP_MAX    = 15;

    // Effective settings after clamping; every field fits the raw register width.
    typedef struct packed {
        logic [WIN_REG_W-1:0] win_w;
        logic [WIN_REG_W-1:0] win_h;
        logic [WIN_REG_W-1:0] step_x;
        logic [WIN_REG_W-1:0] step_y;
        logic [DIM_W-1:0]     plane_w;
        logic [DIM_W-1:0]     plane_h;
    } cfg_t;

    function automatic int unsigned clamp_val(input int unsigned v, input int unsigned hi);
        if (v == 0) begin
            return 1;
        end
        else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

// File: rtl/core/strided_max_pool_argmax.sv
// Strided max pooling with argmax over a raster pixel stream.
// A completing pixel starts a scan, one line store read per window pixel, then the wait
// and emit states register the result. Throughput: one pixel per cycle that completes no
// window; a completing pixel holds the input until the scan ends and the output is free.
// Reset: settings return to 2, 2, 2, 2, 1024, 1024 and the position to the plane start;
// the line store is not cleared, since only pixels of the current plane are read.
`timescale 1ns / 1ps

module strided_max_pool_argmax
    import smpa_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VAL_W-1:0]      s_tdata,     // [15:0] pixel_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // [15:0] pooled_value, [35:16] source_index
    output logic                  m_tlast,     // last_of_plane
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLW = $clog2(MAX_WINDOW);
    localparam int CW  = $clog2(MAX_WIDTH);

    cfg_t             cfg;
    logic             cfg_clear;
    logic             wr_en;
    logic [SLW-1:0]   wr_slot;
    logic [CW-1:0]    wr_col;
    logic [VAL_W-1:0] wr_data;
    logic             rd_en;
    logic [SLW-1:0]   rd_slot;
    logic [CW-1:0]    rd_col;
    logic [VAL_W-1:0] rd_data;
    logic [VAL_W-1:0] m_value;
    logic [IDX_W-1:0] m_index;

    smpa_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_clear (cfg_clear)
    );

    smpa_line_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_slot (wr_slot),
        .wr_col  (wr_col),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_slot (rd_slot),
        .rd_col  (rd_col),
        .rd_data (rd_data)
    );

    smpa_pool #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_clear (cfg_clear),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_value   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_value   (m_value),
        .m_index   (m_index),
        .m_last    (m_tlast),
        .wr_en     (wr_en),
        .wr_slot   (wr_slot),
        .wr_col    (wr_col),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_slot   (rd_slot),
        .rd_col    (rd_col),
        .rd_data   (rd_data)
    );

    assign m_tdata = {{PAD_W{1'b0}}, m_index, m_value};

endmodule

// File: rtl/core/smpa_cfg.sv
// Configuration registers of the pooling block with clamping of each setting.
// Depends on smpa_pkg.
`timescale 1ns / 1ps

module smpa_cfg
    import smpa_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic                  cfg_clear
);

    logic [WIN_REG_W-1:0] win_w_reg;
    logic [WIN_REG_W-1:0] win_h_reg;
    logic [WIN_REG_W-1:0] step_x_reg;
    logic [WIN_REG_W-1:0] step_y_reg;
    logic [DIM_W-1:0]     plane_w_reg;
    logic [DIM_W-1:0]     plane_h_reg;
    logic                 wr_fire;

    assign cfg_ready = 1'b1;
    assign wr_fire   = cfg_valid && cfg_ready;

    // Any write to a known register restarts the plane position.
    assign cfg_clear = wr_fire && (32'(cfg_index) < NUM_REGS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg   <= WIN_RESET;
            win_h_reg   <= WIN_RESET;
            step_x_reg  <= STEP_RESET;
            step_y_reg  <= STEP_RESET;
            plane_w_reg <= PLANE_RESET;
            plane_h_reg <= PLANE_RESET;
        end
        else if (wr_fire)
        begin
            case (cfg_index)
                REG_WIN_W:   win_w_reg   <= cfg_data[WIN_REG_W-1:0];
                REG_WIN_H:   win_h_reg   <= cfg_data[WIN_REG_W-1:0];
                REG_STEP_X:  step_x_reg  <= cfg_data[WIN_REG_W-1:0];
                REG_STEP_Y:  step_y_reg  <= cfg_data[WIN_REG_W-1:0];
                REG_PLANE_W: plane_w_reg <= cfg_data[DIM_W-1:0];
                REG_PLANE_H: plane_h_reg <= cfg_data[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.win_w   = WIN_REG_W'(clamp_val(32'(win_w_reg), MAX_WINDOW));
        cfg.win_h   = WIN_REG_W'(clamp_val(32'(win_h_reg), MAX_WINDOW));
        cfg.step_x  = WIN_REG_W'(clamp_val(32'(step_x_reg), STEP_MAX));
        cfg.step_y  = WIN_REG_W'(clamp_val(32'(step_y_reg), STEP_MAX));
        cfg.plane_w = DIM_W'(clamp_val(32'(plane_w_reg), MAX_WIDTH));
        cfg.plane_h = DIM_W'(clamp_val(32'(plane_h_reg), MAX_HEIGHT));
    end

endmodule

// File: rtl/core/smpa_line_store.sv
// Line store: the most recent MAX_WINDOW rows of the plane in one synchronous
// memory, one write and one registered read per cycle. Depends on smpa_pkg.
`timescale 1ns / 1ps

module smpa_line_store
    import smpa_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 8
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_WINDOW)-1:0] wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
    input  logic [VAL_W-1:0]              wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_WINDOW)-1:0] rd_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
    output logic [VAL_W-1:0]              rd_data
);

    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    // Row slot times the row pitch; the pitch is a constant.
    assign wr_addr = AW'(AW'(wr_slot) * AW'(MAX_WIDTH) + AW'(wr_col));
    assign rd_addr = AW'(AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(rd_col));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/smpa_pool.sv
// Plane position tracking, window scan over the line store, running maximum
// and the output register. Depends on smpa_pkg and drives smpa_line_store.
`timescale 1ns / 1ps

module smpa_pool
    import smpa_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          cfg_clear,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [VAL_W-1:0]              s_value,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [VAL_W-1:0]              m_value,
    output logic [IDX_W-1:0]              m_index,
    output logic                          m_last,
    output logic                          wr_en,
    output logic [$clog2(MAX_WINDOW)-1:0] wr_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
    output logic [VAL_W-1:0]              wr_data,
    output logic                          rd_en,
    output logic [$clog2(MAX_WINDOW)-1:0] rd_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
    input  logic [VAL_W-1:0]              rd_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SLW = $clog2(MAX_WINDOW);
    localparam int MW  = (CW > RW) ? CW : RW;
    localparam int EW  = ((MW > DIM_W) ? MW : DIM_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t                   state_reg;
    logic [CW-1:0]            x_reg;
    logic [RW-1:0]            y_reg;
    logic [SLW-1:0]           slot_reg;
    logic [IDX_W-1:0]         rowbase_reg;
    logic [WIN_REG_W-1:0]     xph_reg;
    logic [WIN_REG_W-1:0]     yph_reg;

    logic [CW-1:0]            col_reg;
    logic [CW-1:0]            col_lo_reg;
    logic [CW-1:0]            col_hi_reg;
    logic [SLW-1:0]           rslot_reg;
    logic [IDX_W-1:0]         rbase_reg;
    logic [SLW-1:0]           rows_left_reg;
    logic                     last_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic signed [VAL_W-1:0]  best_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic                     m_tvalid_reg;
    logic [VAL_W-1:0]         out_value_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic                     out_last_reg;

    logic [EW-1:0]            x_e, y_e, x1, y1, cx, cy;
    logic [EW-1:0]            ww_e, wh_e, sx_e, sy_e, pw_e, ph_e;
    logic                     fits, x_in, y_in, hit, last_win, row_end, plane_end;
    logic                     accept, out_free, take_best;
    logic [WIN_REG_W-1:0]     xph_inc, yph_inc;
    logic [SLW-1:0]           slot_inc, rslot_dec;

    assign x_e  = EW'(x_reg);
    assign y_e  = EW'(y_reg);
    assign ww_e = EW'(cfg.win_w);
    assign wh_e = EW'(cfg.win_h);
    assign sx_e = EW'(cfg.step_x);
    assign sy_e = EW'(cfg.step_y);
    assign pw_e = EW'(cfg.plane_w);
    assign ph_e = EW'(cfg.plane_h);
    assign x1   = x_e + EW'(1);
    assign y1   = y_e + EW'(1);
    assign cx   = x1 - ww_e;
    assign cy   = y1 - wh_e;

    assign fits      = (ww_e <= pw_e) && (wh_e <= ph_e);
    assign x_in      = x1 >= ww_e;
    assign y_in      = y1 >= wh_e;
    // The phase counters hold the window origin offset modulo the step.
    assign hit       = fits && x_in && y_in && (xph_reg == '0) && (yph_reg == '0);
    assign last_win  = (cx + sx_e > pw_e - ww_e) && (cy + sy_e > ph_e - wh_e);
    assign row_end   = x1 == pw_e;
    assign plane_end = row_end && (y1 == ph_e);

    assign xph_inc = (WIN_REG_W'(xph_reg + 1'b1) == cfg.step_x) ? '0 :
                     WIN_REG_W'(xph_reg + 1'b1);
    assign yph_inc = (WIN_REG_W'(yph_reg + 1'b1) == cfg.step_y) ? '0 :
                     WIN_REG_W'(yph_reg + 1'b1);
    assign slot_inc  = (slot_reg == SLW'(MAX_WINDOW - 1)) ? '0 : SLW'(slot_reg + 1'b1);
    assign rslot_dec = (rslot_reg == '0) ? SLW'(MAX_WINDOW - 1) : SLW'(rslot_reg - 1'b1);

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // The scan runs from the bottom-right pixel backward, so taking equal
    // values keeps the first maximum in row-major order.
    assign take_best = rd_vld_reg && ($signed(rd_data) >= best_reg);

    assign wr_en   = accept;
    assign wr_slot = slot_reg;
    assign wr_col  = x_reg;
    assign wr_data = s_value;
    assign rd_en   = state_reg == ST_SCAN;
    assign rd_slot = rslot_reg;
    assign rd_col  = col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg       <= '0;
            y_reg       <= '0;
            slot_reg    <= '0;
            rowbase_reg <= '0;
            xph_reg     <= '0;
            yph_reg     <= '0;
        end
        else if (cfg_clear || (accept && plane_end))
        begin
            x_reg       <= '0;
            y_reg       <= '0;
            slot_reg    <= '0;
            rowbase_reg <= '0;
            xph_reg     <= '0;
            yph_reg     <= '0;
        end
        else if (accept && row_end)
        begin
            x_reg       <= '0;
            xph_reg     <= '0;
            y_reg       <= RW'(y_reg + 1'b1);
            slot_reg    <= slot_inc;
            rowbase_reg <= IDX_W'(rowbase_reg + IDX_W'(cfg.plane_w));
            yph_reg     <= y_in ? yph_inc : '0;
        end
        else if (accept)
        begin
            x_reg   <= CW'(x_reg + 1'b1);
            xph_reg <= x_in ? xph_inc : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            col_lo_reg    <= '0;
            col_hi_reg    <= '0;
            rslot_reg     <= '0;
            rbase_reg     <= '0;
            rows_left_reg <= '0;
            last_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            best_reg      <= VAL_MIN;
            best_idx_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
            out_value_reg <= '0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= state_reg == ST_SCAN;
            rd_idx_reg <= IDX_W'(rbase_reg + IDX_W'(col_reg));

            if (take_best)
            begin
                best_reg     <= $signed(rd_data);
                best_idx_reg <= rd_idx_reg;
            end

            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && hit)
                    begin
                        col_reg       <= x_reg;
                        col_hi_reg    <= x_reg;
                        col_lo_reg    <= CW'(cx);
                        rslot_reg     <= slot_reg;
                        rbase_reg     <= rowbase_reg;
                        rows_left_reg <= SLW'(wh_e - EW'(1));
                        last_reg      <= last_win;
                        best_reg      <= VAL_MIN;
                        best_idx_reg  <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (col_reg == col_lo_reg)
                    begin
                        if (rows_left_reg == '0)
                        begin
                            state_reg <= ST_WAIT;
                        end
                        else
                        begin
                            col_reg       <= col_hi_reg;
                            rows_left_reg <= SLW'(rows_left_reg - 1'b1);
                            rslot_reg     <= rslot_dec;
                            rbase_reg     <= IDX_W'(rbase_reg - IDX_W'(cfg.plane_w));
                        end
                    end
                    else
                    begin
                        col_reg <= CW'(col_reg - 1'b1);
                    end
                end
                ST_WAIT:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        out_value_reg <= best_reg;
                        // A window that never rose above the minimum reports index zero.
                        out_idx_reg   <= (best_reg == VAL_MIN) ? '0 : best_idx_reg;
                        out_last_reg  <= last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_value  = out_value_reg;
    assign m_index  = out_idx_reg;
    assign m_last   = out_last_reg;

    a_col_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
        x_e < pw_e)
        else $error("column position outside the plane");

    a_row_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
        y_e < ph_e)
        else $error("row position outside the plane");

    a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
        rowbase_reg == IDX_W'(32'(y_reg) * 32'(cfg.plane_w)))
        else $error("row base index out of step with the row position");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == ST_SCAN || state_reg == ST_WAIT))
        else $error("line store data compared outside a window scan");

endmodule
